### rtl/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_W    = 12;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_AW    = FRAME_W - BIT_W;
  localparam int LIMIT_W    = $clog2(MAP_WORDS + 1);
  localparam int FC_W       = 13;
  localparam logic [FC_W-1:0] FC_RESET = FC_W'(MAX_FRAMES);
  localparam logic [FC_W-1:0] FC_MAX   = FC_W'(MAX_FRAMES);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TEST  = 2'd2,
    OP_MARK  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NO_CHANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [FRAME_W-1:0] page_frame;
    logic               kernel_mode;
    logic               rw_page;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic               present;
    logic               writable;
    logic               user;
    logic [1:0]         status;
    logic               bit_set;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SCAN,
    S_EXEC,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_NO_CHANGE,
    RES_NO_FREE,
    RES_EXEC,
    RES_ALLOC
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     rd_en;
    logic     rd_scan;
    logic     scan_adv;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       pf_zero;
    logic       limit_zero;
    logic       word_full;
    logic       scan_last;
  } stat_t;

endpackage

### rtl/bfa_ctrl.sv
// Request sequencer for the bitmap frame allocator.
module bfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           done,
  input  bfa_pkg::stat_t stat,
  output bfa_pkg::cmd_t  cmd
);

  bfa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.rd_scan  = 1'b0;
    cmd.scan_adv = 1'b0;
    cmd.res_sel  = bfa_pkg::RES_HOLD;
    busy         = (state_r != bfa_pkg::S_IDLE);
    done         = 1'b0;
    unique case (state_r)
      bfa_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = bfa_pkg::S_RD;
        end
      end
      bfa_pkg::S_RD: begin
        priority if (stat.opcode == bfa_pkg::OP_ALLOC && !stat.pf_zero) begin
          cmd.res_sel = bfa_pkg::RES_NO_CHANGE;
          state_nxt   = bfa_pkg::S_DONE;
        end else if (stat.opcode == bfa_pkg::OP_FREE && stat.pf_zero) begin
          cmd.res_sel = bfa_pkg::RES_NO_CHANGE;
          state_nxt   = bfa_pkg::S_DONE;
        end else if (stat.opcode == bfa_pkg::OP_ALLOC && stat.limit_zero) begin
          cmd.res_sel = bfa_pkg::RES_NO_FREE;
          state_nxt   = bfa_pkg::S_DONE;
        end else if (stat.opcode == bfa_pkg::OP_ALLOC) begin
          cmd.rd_en = 1'b1;
          state_nxt = bfa_pkg::S_SCAN;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = bfa_pkg::S_EXEC;
        end
      end
      bfa_pkg::S_SCAN: begin
        priority if (!stat.word_full) begin
          cmd.res_sel = bfa_pkg::RES_ALLOC;
          state_nxt   = bfa_pkg::S_DONE;
        end else if (stat.scan_last) begin
          cmd.res_sel = bfa_pkg::RES_NO_FREE;
          state_nxt   = bfa_pkg::S_DONE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_scan  = 1'b1;
          cmd.scan_adv = 1'b1;
        end
      end
      bfa_pkg::S_EXEC: begin
        cmd.res_sel = bfa_pkg::RES_EXEC;
        state_nxt   = bfa_pkg::S_DONE;
      end
      bfa_pkg::S_DONE: begin
        done      = 1'b1;
        state_nxt = bfa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bfa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/bfa_datapath.sv
// Bitmap memory, scan counter, request and result registers.
module bfa_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bfa_pkg::FC_W-1:0]  cfg_wdata,
  input  bfa_pkg::req_t             in_req,
  input  bfa_pkg::cmd_t             cmd,
  output bfa_pkg::stat_t            stat,
  output bfa_pkg::res_t             out_res
);

  logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::MAP_WORDS];
  logic [bfa_pkg::MAP_WORDS-1:0] valid_r;
  logic [bfa_pkg::WORD_BITS-1:0] rdata_r;
  logic                          rvld_r;
  logic [bfa_pkg::FC_W-1:0]      fc_r;
  logic [bfa_pkg::WORD_AW-1:0]   cnt_r;
  bfa_pkg::req_t                 req_r;
  bfa_pkg::res_t                 res_r, res_nxt;

  logic [bfa_pkg::FC_W-1:0]      fc_lim;
  logic [bfa_pkg::LIMIT_W-1:0]   limit_words;
  logic [bfa_pkg::WORD_AW-1:0]   req_word;
  logic [bfa_pkg::BIT_W-1:0]     req_bit;
  logic [bfa_pkg::WORD_AW-1:0]   raddr;
  logic [bfa_pkg::WORD_BITS-1:0] word_eff;
  logic [bfa_pkg::BIT_W-1:0]     zero_idx;
  logic [bfa_pkg::WORD_BITS-1:0] req_mask;
  logic                          we;
  logic [bfa_pkg::WORD_AW-1:0]   waddr;
  logic [bfa_pkg::WORD_BITS-1:0] wdata;

  assign fc_lim      = (fc_r > bfa_pkg::FC_MAX) ? bfa_pkg::FC_MAX : fc_r;
  assign limit_words = bfa_pkg::LIMIT_W'(fc_lim >> bfa_pkg::BIT_W);
  assign req_word    = req_r.page_frame[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
  assign req_bit     = req_r.page_frame[bfa_pkg::BIT_W-1:0];
  assign req_mask    = bfa_pkg::WORD_BITS'(1) << req_bit;
  assign word_eff    = rvld_r ? rdata_r : '0;

  always_comb begin
    priority if (cmd.rd_scan) begin
      raddr = cnt_r + bfa_pkg::WORD_AW'(1);
    end else if (req_r.opcode == bfa_pkg::OP_ALLOC) begin
      raddr = cnt_r;
    end else begin
      raddr = req_word;
    end
  end

  always_comb begin
    zero_idx = '0;
    for (int i = bfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!word_eff[i]) begin
        zero_idx = bfa_pkg::BIT_W'(i);
      end
    end
  end

  assign stat.opcode     = req_r.opcode;
  assign stat.pf_zero    = (req_r.page_frame == '0);
  assign stat.limit_zero = (limit_words == '0);
  assign stat.word_full  = (&word_eff);
  assign stat.scan_last  = ((bfa_pkg::LIMIT_W'(cnt_r) + bfa_pkg::LIMIT_W'(1)) == limit_words);

  always_comb begin
    we      = 1'b0;
    waddr   = req_word;
    wdata   = word_eff;
    res_nxt = res_r;
    unique case (cmd.res_sel)
      bfa_pkg::RES_HOLD: begin
        res_nxt = res_r;
      end
      bfa_pkg::RES_NO_CHANGE: begin
        res_nxt              = '0;
        res_nxt.status       = bfa_pkg::ST_NO_CHANGE;
        res_nxt.frame_number = (req_r.opcode == bfa_pkg::OP_FREE) ? '0 : req_r.page_frame;
      end
      bfa_pkg::RES_NO_FREE: begin
        res_nxt        = '0;
        res_nxt.status = bfa_pkg::ST_NO_FREE;
      end
      bfa_pkg::RES_ALLOC: begin
        we                   = 1'b1;
        waddr                = cnt_r;
        wdata                = word_eff | (bfa_pkg::WORD_BITS'(1) << zero_idx);
        res_nxt              = '0;
        res_nxt.frame_number = {cnt_r, zero_idx};
        res_nxt.present      = 1'b1;
        res_nxt.writable     = req_r.rw_page;
        res_nxt.user         = ~req_r.kernel_mode;
        res_nxt.status       = bfa_pkg::ST_OK;
      end
      bfa_pkg::RES_EXEC: begin
        res_nxt              = '0;
        res_nxt.status       = bfa_pkg::ST_OK;
        res_nxt.frame_number = req_r.page_frame;
        unique case (req_r.opcode)
          bfa_pkg::OP_FREE: begin
            we                   = 1'b1;
            wdata                = word_eff & ~req_mask;
            res_nxt.frame_number = '0;
          end
          bfa_pkg::OP_MARK: begin
            we    = 1'b1;
            wdata = word_eff | req_mask;
          end
          bfa_pkg::OP_TEST: begin
            res_nxt.bit_set = word_eff[req_bit];
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
      fc_r    <= bfa_pkg::FC_RESET;
      cnt_r   <= '0;
    end else begin
      if (cmd.rd_en) begin
        rvld_r <= valid_r[raddr];
      end
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (cfg_we) begin
        fc_r <= cfg_wdata;
      end
      if (cmd.capture) begin
        cnt_r <= '0;
      end else if (cmd.scan_adv) begin
        cnt_r <= cnt_r + bfa_pkg::WORD_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
    res_r <= res_nxt;
  end

  assign out_res = res_r;

endmodule

### rtl/bitmap_frame_allocator_core.sv
// Top level of the first-fit bitmap frame allocator.
//
// One request at a time: a request is taken when start is high and busy is
// low, and its single result shows on out_res for one cycle with out_valid.
// The receiver cannot stall. Free, mark and test pass from the read state
// through the execute state to the result; alloc with a frame already
// present, free of frame zero, or a zero-word search go from the read state
// straight to the result; an alloc search reads the 32-bit bitmap words,
// one per cycle through the single read port of the bitmap memory, at most
// 128 of them. busy is low again the cycle after out_valid. Reset clears
// the map at once through per-word valid bits; no clearing pass is needed.
module bitmap_frame_allocator_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  bfa_pkg::req_t            in_req,
  output logic                     out_valid,
  output bfa_pkg::res_t            out_res,
  input  logic                     cfg_we,
  input  logic [bfa_pkg::FC_W-1:0] cfg_wdata
);

  bfa_pkg::cmd_t  cmd;
  bfa_pkg::stat_t stat;

  bfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .stat  (stat),
    .cmd   (cmd)
  );

  bfa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_res   (out_res)
  );

endmodule

### rtl/bfa_checker.sv
// Port-level assertions for the bitmap frame allocator, bound to the top level.
module bfa_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input bfa_pkg::res_t out_res
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy ##1 !busy))
    else $error("result outside a busy request");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.status <= bfa_pkg::ST_NO_CHANGE))
    else $error("undefined status code");

  a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.present) |->
      (out_res.status == bfa_pkg::ST_OK && !out_res.bit_set))
    else $error("present flag without a successful alloc");

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

### sim/frame_alloc_tb_pkg.sv
// Scoreboard for the bitmap frame allocator: frame map predictor and result checker.
package frame_alloc_tb_pkg;
  import bfa_pkg::*;

  class frame_map_scoreboard;
    logic [WORD_BITS-1:0] used_words [MAP_WORDS];
    logic [FC_W-1:0]      frame_limit;
    res_t                 expected_q [$];
    int unsigned          mismatches;

    function new();
      foreach (used_words[i]) used_words[i] = '0;
      frame_limit = FC_RESET;
      mismatches  = 0;
    endfunction

    function void write_frame_limit(logic [FC_W-1:0] value);
      frame_limit = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic frame_used(logic [FRAME_W-1:0] frame);
      return used_words[frame[FRAME_W-1:BIT_W]][frame[BIT_W-1:0]];
    endfunction

    function void put_frame_bit(logic [FRAME_W-1:0] frame, logic value);
      used_words[frame[FRAME_W-1:BIT_W]][frame[BIT_W-1:0]] = value;
    endfunction

    // First fit over whole words only; the span saturates at the map size.
    function bit find_lowest_free(output logic [FRAME_W-1:0] frame);
      int unsigned span;
      int unsigned words;
      span  = (frame_limit > FC_MAX) ? MAX_FRAMES : int'(frame_limit);
      words = span / WORD_BITS;
      frame = '0;
      for (int w = 0; w < words; w++) begin
        for (int b = 0; b < WORD_BITS; b++) begin
          if (!used_words[w][b]) begin
            frame = FRAME_W'(w * WORD_BITS + b);
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(req_t req);
      res_t               want;
      logic [FRAME_W-1:0] frame;
      want              = '0;
      want.frame_number = req.page_frame;
      want.status       = ST_OK;
      case (opcode_t'(req.opcode))
        OP_ALLOC: begin
          if (req.page_frame != '0) begin
            want.status = ST_NO_CHANGE;
          end else if (!find_lowest_free(frame)) begin
            want.frame_number = '0;
            want.status       = ST_NO_FREE;
          end else begin
            put_frame_bit(frame, 1'b1);
            want.frame_number = frame;
            want.present      = 1'b1;
            want.writable     = req.rw_page;
            want.user         = ~req.kernel_mode;
          end
        end
        OP_FREE: begin
          if (req.page_frame == '0) begin
            want.status = ST_NO_CHANGE;
          end else begin
            put_frame_bit(req.page_frame, 1'b0);
          end
          want.frame_number = '0;
        end
        OP_TEST: want.bit_set = frame_used(req.page_frame);
        default: put_frame_bit(req.page_frame, 1'b1);
      endcase
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request waiting: frame_number 0x%0h", got.frame_number);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("frame_number", 32'(want.frame_number), 32'(got.frame_number));
      compare_field("present", 32'(want.present), 32'(got.present));
      compare_field("writable", 32'(want.writable), 32'(got.writable));
      compare_field("user", 32'(want.user), 32'(got.user));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("bit_set", 32'(want.bit_set), 32'(got.bit_set));
    endfunction
  endclass

endpackage

### sim/tb_top.sv
// Testbench top for bitmap_frame_allocator_core: stimulus, monitor and watchdog.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;
  import frame_alloc_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int PHASE_ITEMS    = 154;
  localparam int NUM_PHASES     = 8;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  req_t            in_req;
  logic            out_valid;
  res_t            out_res;
  logic            cfg_we;
  logic [FC_W-1:0] cfg_wdata;

  frame_map_scoreboard sb;
  int              idle_cycles;

  int unsigned phase_frames [NUM_PHASES] = '{32, 0, 64, 8191, 31, 100, 4095, 4096};
  int unsigned phase_allocs [NUM_PHASES] = '{70, 50, 70, 55, 50, 65, 55, 60};

  bitmap_frame_allocator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result(out_res);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic req_t make_req(opcode_t op, logic [FRAME_W-1:0] frame,
                                    logic kernel, logic writeable);
    req_t req;
    req.opcode      = op;
    req.page_frame  = frame;
    req.kernel_mode = kernel;
    req.rw_page     = writeable;
    return req;
  endfunction

  function automatic req_t rand_request(int unsigned alloc_pct);
    req_t        req;
    int unsigned pick;
    req.kernel_mode = 1'($urandom_range(0, 1));
    req.rw_page     = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < alloc_pct) begin
      req.opcode     = OP_ALLOC;
      req.page_frame = ($urandom_range(0, 4) != 0) ? '0 : FRAME_W'($urandom_range(0, 4095));
      return req;
    end
    pick = $urandom_range(0, 9);
    req.opcode = (pick < 5) ? OP_FREE : (pick < 8) ? OP_TEST : OP_MARK;
    pick = $urandom_range(0, 9);
    case (pick)
      6:       req.page_frame = '0;
      7:       req.page_frame = '1;
      8, 9:    req.page_frame = FRAME_W'($urandom_range(0, 4095));
      default: req.page_frame = FRAME_W'($urandom_range(0, 255));
    endcase
    return req;
  endfunction

  // Leaves start high; the caller either sends again or drops start in the same step.
  task automatic send_request(req_t req);
    in_req <= req;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(req);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [FC_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_frame_limit(value);
  endtask

  task automatic run_directed();
    send_request(make_req(OP_TEST, 12'd0, 1'b0, 1'b0));
    send_request(make_req(OP_ALLOC, 12'd0, 1'b0, 1'b1));
    send_request(make_req(OP_ALLOC, 12'd0, 1'b1, 1'b0));
    send_request(make_req(OP_ALLOC, 12'hFFF, 1'b1, 1'b1));
    send_request(make_req(OP_ALLOC, 12'hAAA, 1'b0, 1'b0));
    send_request(make_req(OP_TEST, 12'd0, 1'b1, 1'b1));
    send_request(make_req(OP_FREE, 12'd0, 1'b0, 1'b0));
    send_request(make_req(OP_FREE, 12'd1, 1'b1, 1'b1));
    send_request(make_req(OP_FREE, 12'd1, 1'b0, 1'b0));
    send_request(make_req(OP_MARK, 12'hFFF, 1'b0, 1'b0));
    send_request(make_req(OP_TEST, 12'hFFF, 1'b0, 1'b0));
    send_request(make_req(OP_MARK, 12'd2, 1'b1, 1'b0));
    send_request(make_req(OP_ALLOC, 12'd0, 1'b0, 1'b0));
    send_request(make_req(OP_ALLOC, 12'd0, 1'b1, 1'b1));
    send_request(make_req(OP_FREE, 12'hFFF, 1'b0, 1'b1));
    send_request(make_req(OP_TEST, 12'hFFF, 1'b0, 1'b0));
    send_request(make_req(OP_TEST, 12'h555, 1'b1, 1'b0));
    send_request(make_req(OP_MARK, 12'h800, 1'b0, 1'b1));
    send_request(make_req(OP_TEST, 12'h800, 1'b1, 1'b1));
    send_request(make_req(OP_FREE, 12'h800, 1'b1, 1'b0));
    start <= 1'b0;
  endtask

  task automatic run_phase(int unsigned count, int unsigned alloc_pct);
    int unsigned left;
    int unsigned len;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      if (len > left) len = left;
      repeat (len) begin
        send_request(rand_request(alloc_pct));
        left--;
      end
      if (left > 0 && $urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    sb        = new();
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_frame_count(FC_W'(4096));
    run_directed();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_frame_count(FC_W'(phase_frames[p]));
      run_phase(PHASE_ITEMS, phase_allocs[p]);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### bitmap_frame_allocator_core.f
rtl/bfa_pkg.sv
rtl/bfa_ctrl.sv
rtl/bfa_datapath.sv
rtl/bitmap_frame_allocator_core.sv
rtl/bfa_checker.sv
sim/frame_alloc_tb_pkg.sv
sim/tb_top.sv
